// ----- rtl/atb_pkg.sv -----
// Package with the word types, command and result codes, and sizing constants of the alarm bank.
`default_nettype none
package atb_pkg;

  localparam int NUM_ALARMS_DEF = 8;
  localparam int OP_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH = 4;

  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_SET_REL   = 3'd1;
  localparam logic [2:0] CMD_SET_ABS   = 3'd2;
  localparam logic [2:0] CMD_CANCEL    = 3'd3;
  localparam logic [2:0] CMD_READ      = 3'd4;
  localparam logic [2:0] CMD_READ_TICK = 3'd5;

  localparam logic [2:0] KIND_ACK    = 3'd0;
  localparam logic [2:0] KIND_FIRED  = 3'd1;
  localparam logic [2:0] KIND_REMAIN = 3'd2;
  localparam logic [2:0] KIND_TICK   = 3'd3;
  localparam logic [2:0] KIND_BAD_ID = 3'd4;

  typedef struct packed {
    logic [2:0]  command;
    logic [5:0]  alarm_id;
    logic [31:0] start_value;
    logic [31:0] cycle_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  fired_id;
    logic [31:0] value;
    logic        last;
  } out_word_t;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_SET_REL,
    OP_SET_ABS,
    OP_CANCEL,
    OP_READ,
    OP_READ_TICK,
    OP_ACK,
    OP_BAD_ID
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [5:0]  alarm_id;
    logic [31:0] start_value;
    logic [31:0] cycle_value;
  } op_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_READ
  } exec_state_t;

endpackage
`default_nettype wire

// ----- rtl/atb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module atb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic                  re,
  input  wire logic [AW-1:0]         raddr,
  output logic      [WIDTH-1:0]      rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- rtl/atb_fifo.sv -----
// Small first-in first-out queue with show-ahead read data.
`default_nettype none
module atb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/atb_front.sv -----
// Front end that decodes each accepted word and range-checks set/cancel/read ids.
`default_nettype none
module atb_front import atb_pkg::*; #(
  parameter int NUM_ALARMS = NUM_ALARMS_DEF
) (
  input  wire logic     in_push,
  input  wire in_word_t in_word,
  output logic          in_full,
  output logic          op_push,
  output op_word_t      op_word,
  input  wire logic     op_full
);
  logic id_ok;

  assign id_ok   = ({1'b0, in_word.alarm_id} < 7'(NUM_ALARMS));
  assign in_full = op_full;
  assign op_push = in_push;

  always_comb begin
    op_word.alarm_id    = in_word.alarm_id;
    op_word.start_value = in_word.start_value;
    op_word.cycle_value = in_word.cycle_value;
    case (in_word.command)
      CMD_TICK:      op_word.op = OP_TICK;
      CMD_READ_TICK: op_word.op = OP_READ_TICK;
      CMD_SET_REL:   op_word.op = id_ok ? OP_SET_REL : OP_BAD_ID;
      CMD_SET_ABS:   op_word.op = id_ok ? OP_SET_ABS : OP_BAD_ID;
      CMD_CANCEL:    op_word.op = id_ok ? OP_CANCEL : OP_BAD_ID;
      CMD_READ:      op_word.op = id_ok ? OP_READ : OP_BAD_ID;
      default:       op_word.op = OP_ACK;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/atb_exec.sv -----
// Back end that executes decoded operations on the tick counter and the alarm table.
`default_nettype none
module atb_exec import atb_pkg::*; #(
  parameter int NUM_ALARMS = NUM_ALARMS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     op_empty,
  input  wire op_word_t op_word,
  output logic          op_pop,
  output logic          res_push,
  output out_word_t     res_word,
  input  wire logic     res_full
);
  localparam int IDX_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
  localparam int CNT_W = $clog2(NUM_ALARMS + 1);

  exec_state_t            state_r, state_nxt;
  logic [31:0]            tick_r, tick_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]       pend_idx_r, pend_idx_nxt;
  logic                   held_v_r, held_v_nxt;
  logic [5:0]             held_id_r, held_id_nxt;
  logic [NUM_ALARMS-1:0]  valid_r, valid_nxt;

  logic                   ram_we, ram_re;
  logic [IDX_W-1:0]       ram_waddr, ram_raddr, op_idx;
  logic [63:0]            ram_wdata, ram_rdata;
  logic [31:0]            cur_rem, cur_per, dec_rem;

  function automatic out_word_t mk_word(logic [2:0] kind, logic [5:0] id,
                                        logic [31:0] value, logic last);
    out_word_t w;
    w.kind     = kind;
    w.fired_id = id;
    w.value    = value;
    w.last     = last;
    return w;
  endfunction

  atb_ram #(
    .WIDTH (64),
    .DEPTH (NUM_ALARMS)
  ) u_alarm_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // An entry never written since reset reads as an inactive alarm.
  assign cur_rem = valid_r[pend_idx_r] ? ram_rdata[31:0] : '0;
  assign cur_per = valid_r[pend_idx_r] ? ram_rdata[63:32] : '0;
  assign dec_rem = cur_rem - 32'd1;
  assign op_idx  = op_word.alarm_id[IDX_W-1:0];

  always_comb begin
    state_nxt    = state_r;
    tick_nxt     = tick_r;
    idx_nxt      = idx_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    held_v_nxt   = held_v_r;
    held_id_nxt  = held_id_r;
    valid_nxt    = valid_r;
    op_pop       = 1'b0;
    res_push     = 1'b0;
    res_word     = mk_word(KIND_ACK, 6'd0, 32'd0, 1'b1);
    ram_we       = 1'b0;
    ram_waddr    = op_idx;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = op_idx;
    case (state_r)
      ST_IDLE: begin
        if (!op_empty && !res_full) begin
          op_pop = 1'b1;
          case (op_word.op)
            OP_TICK: begin
              tick_nxt   = tick_r + 32'd1;
              idx_nxt    = '0;
              pend_v_nxt = 1'b0;
              held_v_nxt = 1'b0;
              state_nxt  = ST_TICK;
            end
            OP_SET_REL: begin
              ram_we            = 1'b1;
              ram_wdata         = {op_word.cycle_value, op_word.start_value};
              valid_nxt[op_idx] = 1'b1;
              res_push          = 1'b1;
            end
            OP_SET_ABS: begin
              ram_we            = 1'b1;
              ram_wdata         = {op_word.cycle_value, op_word.start_value - tick_r};
              valid_nxt[op_idx] = 1'b1;
              res_push          = 1'b1;
            end
            OP_CANCEL: begin
              ram_we            = 1'b1;
              valid_nxt[op_idx] = 1'b1;
              res_push          = 1'b1;
            end
            OP_READ: begin
              ram_re       = 1'b1;
              pend_idx_nxt = op_idx;
              state_nxt    = ST_READ;
            end
            OP_READ_TICK: begin
              res_push = 1'b1;
              res_word = mk_word(KIND_TICK, 6'd0, tick_r, 1'b1);
            end
            OP_BAD_ID: begin
              res_push = 1'b1;
              res_word = mk_word(KIND_BAD_ID, op_word.alarm_id, 32'd0, 1'b1);
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        res_push  = 1'b1;
        res_word  = mk_word(KIND_REMAIN, 6'(pend_idx_r), cur_rem, 1'b1);
        state_nxt = ST_IDLE;
      end
      ST_TICK: begin
        // One fired event is held back so the final one can be marked last.
        if (!res_full) begin
          if (pend_v_r && (cur_rem != '0)) begin
            ram_we    = 1'b1;
            ram_waddr = pend_idx_r;
            if (dec_rem == '0) begin
              ram_wdata   = {cur_per, cur_per};
              res_push    = held_v_r;
              res_word    = mk_word(KIND_FIRED, held_id_r, 32'd0, 1'b0);
              held_v_nxt  = 1'b1;
              held_id_nxt = 6'(pend_idx_r);
            end else begin
              ram_wdata = {cur_per, dec_rem};
            end
          end
          if (idx_r < CNT_W'(NUM_ALARMS)) begin
            ram_re       = 1'b1;
            ram_raddr    = idx_r[IDX_W-1:0];
            pend_v_nxt   = 1'b1;
            pend_idx_nxt = idx_r[IDX_W-1:0];
            idx_nxt      = idx_r + 1'b1;
          end else begin
            pend_v_nxt = 1'b0;
            if (!pend_v_r) begin
              res_push  = 1'b1;
              res_word  = held_v_r ? mk_word(KIND_FIRED, held_id_r, 32'd0, 1'b1)
                                   : mk_word(KIND_ACK, 6'd0, 32'd0, 1'b1);
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      tick_r   <= '0;
      idx_r    <= '0;
      pend_v_r <= 1'b0;
      held_v_r <= 1'b0;
      valid_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      tick_r   <= tick_nxt;
      idx_r    <= idx_nxt;
      pend_v_r <= pend_v_nxt;
      held_v_r <= held_v_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    held_id_r  <= held_id_nxt;
  end

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (state_r == ST_IDLE))
    else $error("alarm read did not complete in one cycle");

  a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("alarm entry read and written in the same cycle");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_v_r)
    else $error("tick walk left an entry pending");
`endif

endmodule
`default_nettype wire

// ----- rtl/alarm_timer_bank.sv -----
// Every word goes through the command queue, the executor and the result
// queue in turn; an alarm read also waits for the registered read of the alarm table.
// The executor takes no new word until an alarm read or a tick is done, and it stalls
// while the result queue is full; otherwise a tick reads one alarm table entry per cycle.
// Reset (rst_n low, synchronous) empties both queues, clears the tick counter and
// marks every alarm entry unwritten, so all alarms read as inactive at once.
`default_nettype none
module alarm_timer_bank import atb_pkg::*; #(
  parameter int NUM_ALARMS = NUM_ALARMS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_push,
  input  wire in_word_t  in_word,
  output logic           in_full,
  input  wire logic      out_pop,
  output out_word_t      out_word,
  output logic           out_empty
);
  localparam int OP_W  = $bits(op_word_t);
  localparam int RES_W = $bits(out_word_t);

  logic              op_push, op_full, op_empty, op_pop;
  op_word_t          fe_op, q_op;
  logic [OP_W-1:0]   q_op_bits;
  logic              res_push, res_full;
  out_word_t         res_word;
  logic [RES_W-1:0]  res_bits;

  atb_front #(
    .NUM_ALARMS (NUM_ALARMS)
  ) u_front (
    .in_push (in_push),
    .in_word (in_word),
    .in_full (in_full),
    .op_push (op_push),
    .op_word (fe_op),
    .op_full (op_full)
  );

  atb_fifo #(
    .WIDTH (OP_W),
    .DEPTH (OP_Q_DEPTH)
  ) u_op_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (op_push),
    .wdata (OP_W'(fe_op)),
    .full  (op_full),
    .pop   (op_pop),
    .rdata (q_op_bits),
    .empty (op_empty)
  );

  assign q_op = op_word_t'(q_op_bits);

  atb_exec #(
    .NUM_ALARMS (NUM_ALARMS)
  ) u_exec (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_empty (op_empty),
    .op_word  (q_op),
    .op_pop   (op_pop),
    .res_push (res_push),
    .res_word (res_word),
    .res_full (res_full)
  );

  atb_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (RES_W'(res_word)),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_bits),
    .empty (out_empty)
  );

  assign out_word = out_word_t'(res_bits);

endmodule
`default_nettype wire
